// ===== rtl/core/edf_pkg.sv =====
package edf_pkg;

  localparam int unsigned TaskCount = 8;
  localparam int unsigned TaskIdxW = $clog2(TaskCount);
  localparam logic [19:0] SliceReset = 20'd10000;
  localparam logic [23:0] UtilMax = 24'hFFFFFF;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdDecide = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  task_index;
    logic [31:0] load_deadline;
    logic [31:0] load_exec_time;
    logic [7:0]  alive_mask;
    logic [39:0] now_us;
  } req_t;

  typedef struct packed {
    logic       selection_valid;
    logic [2:0] chosen_task;
    logic       high_freq;
  } rsp_t;

  typedef struct packed {
    logic signed [40:0] dl;
    logic [39:0]        stamp;
    logic signed [32:0] ex;
  } entry_t;

endpackage

// ===== rtl/core/edf_task_picker_with_freq_hint_core.sv =====
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    edf_pkg::req_t
// rsp       out        rsp_valid/stall    edf_pkg::rsp_t
// cfg       in         cfg_valid/ready    time_slice, 20 bits
// A decision visits each task in turn with a read, an update and a step state, plus a bit-serial
// division for each alive task with a positive deadline and estimate, then charges the chosen
// task, if any, and issues the result.
// Reset clears the task states in flip-flops as invalid, so no clearing pass is needed.
// The result register holds while the output is stalled; the next request is
// accepted only once the result has left.
module edf_task_picker_with_freq_hint_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid,
  output logic           req_stall,
  input  edf_pkg::req_t  req_data_i,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output edf_pkg::rsp_t  rsp_data_o,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [19:0]    cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StUpd  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StNext = 3'd4;
  localparam logic [2:0] StChg  = 3'd5;
  localparam logic [2:0] StChgW = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;
  localparam int unsigned IdxW = edf_pkg::TaskIdxW;

  logic [2:0] state_q, state_d;
  logic [19:0] slice_q;
  logic [31:0] pdl_mem [edf_pkg::TaskCount];
  logic [31:0] pex_mem [edf_pkg::TaskCount];
  edf_pkg::entry_t ent_mem [edf_pkg::TaskCount];
  logic [edf_pkg::TaskCount-1:0] init_q, was_q;
  logic [31:0] pdl_rd_q, pex_rd_q;
  edf_pkg::entry_t ent_rd_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW:0] cnt_q;
  edf_pkg::req_t req_q;
  logic [23:0] util_q, old_util_q;
  logic best_v_q;
  logic [IdxW-1:0] best_q;
  logic signed [40:0] best_dl_q;
  logic [56:0] rem_q;
  logic [55:0] quo_q;
  logic [5:0] dcnt_q;
  logic [40:0] div_q;
  logic [48:0] dvd_q;
  logic rsp_valid_q;
  edf_pkg::rsp_t rsp_q;

  logic alive;
  logic signed [40:0] dl_raw;
  logic signed [41:0] dl_sum;
  logic signed [40:0] dl_new;
  edf_pkg::entry_t upd;
  edf_pkg::entry_t chg;
  logic [56:0] rem_sh;
  logic q_bit;
  logic [55:0] quo_nx;
  logic [24:0] usum;
  logic [23:0] ratio;
  logic signed [33:0] ex_sub;

  assign req_stall = (state_q != StIdle) || rsp_valid_q;
  assign cfg_ready = 1'b1;
  assign rsp_valid = rsp_valid_q;
  assign rsp_data_o = rsp_q;

  assign alive = req_q.alive_mask[idx_q];
  assign dl_raw = init_q[idx_q] ? ent_rd_q.dl : '0;
  assign dl_sum = 42'(dl_raw) - 42'($signed({2'b00, req_q.now_us}))
                + 42'($signed({2'b00, (init_q[idx_q] ? ent_rd_q.stamp : 40'd0)}));
  assign dl_new = (dl_sum > 42'sh0FFFFFFFFFF) ? 41'sh0FFFFFFFFFF :
                  (dl_sum < -42'sh10000000000) ? 41'sh10000000000 : dl_sum[40:0];

  always_comb begin
    upd = ent_rd_q;
    if (!init_q[idx_q]) begin
      upd = '0;
    end
    if (!alive && was_q[idx_q]) begin
      upd.dl = '0;
      upd.ex = '0;
    end else if (alive && !was_q[idx_q]) begin
      upd.dl = 41'($signed({9'd0, pdl_rd_q}));
      upd.stamp = req_q.now_us;
      upd.ex = 33'($signed({1'b0, pex_rd_q}));
    end else if (alive) begin
      upd.dl = dl_new;
      upd.stamp = req_q.now_us;
    end
  end

  assign rem_sh = {rem_q[55:0], dvd_q[48]};
  assign q_bit = rem_sh >= {16'd0, div_q};
  assign quo_nx = {quo_q[54:0], q_bit};
  assign ratio = (quo_nx[55:24] != '0) ? edf_pkg::UtilMax : quo_nx[23:0];
  assign usum = {1'b0, util_q} + {1'b0, ratio};
  assign ex_sub = 34'(ent_rd_q.ex) - 34'($signed({14'd0, slice_q}));

  always_comb begin
    chg = ent_rd_q;
    chg.ex = (ex_sub < -34'sh100000000) ? 33'sh100000000 : ex_sub[32:0];
    if (ent_rd_q.dl < 41'($signed({21'd0, slice_q}))) chg.ex = '0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (req_valid && !req_stall && req_data_i.cmd == edf_pkg::CmdDecide) begin
        state_d = StRead;
      end
      StRead: state_d = StUpd;
      StUpd: begin
        if (alive && upd.dl > 0 && upd.ex > 0) state_d = StDiv;
        else state_d = StNext;
      end
      StDiv: if (dcnt_q == 6'd48) state_d = StNext;
      StNext: begin
        if (cnt_q == (IdxW+1)'(edf_pkg::TaskCount - 1)) begin
          state_d = best_v_q ? StChg : StOut;
        end else begin
          state_d = StRead;
        end
      end
      StChg: state_d = StChgW;
      StChgW: state_d = StOut;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_valid && !req_stall && req_data_i.cmd == edf_pkg::CmdLoad
        && 32'(req_data_i.task_index) < edf_pkg::TaskCount) begin
      pdl_mem[req_data_i.task_index[IdxW-1:0]] <= req_data_i.load_deadline;
      pex_mem[req_data_i.task_index[IdxW-1:0]] <= req_data_i.load_exec_time;
    end
    pdl_rd_q <= pdl_mem[idx_q];
    pex_rd_q <= pex_mem[idx_q];
    ent_rd_q <= ent_mem[state_q == StChg ? best_q : idx_q];
    if (state_q == StUpd) begin
      ent_mem[idx_q] <= upd;
    end else if (state_q == StChgW) begin
      ent_mem[best_q] <= chg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid && !req_stall) req_q <= req_data_i;
    if (state_q == StUpd) begin
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= {17'd0, upd.ex[31:0]} << 16;
      div_q <= upd.dl;
    end else if (state_q == StDiv) begin
      if (q_bit) begin
        rem_q <= rem_sh - {16'd0, div_q};
      end else begin
        rem_q <= rem_sh;
      end
      quo_q <= quo_nx;
      dvd_q <= {dvd_q[47:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      slice_q <= edf_pkg::SliceReset;
      init_q <= '0;
      was_q <= '0;
      idx_q <= '0;
      cnt_q <= '0;
      util_q <= '0;
      old_util_q <= '0;
      best_v_q <= 1'b0;
      best_q <= '0;
      best_dl_q <= '0;
      dcnt_q <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) slice_q <= cfg_data_i;
      if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          idx_q <= '0;
          cnt_q <= '0;
          util_q <= '0;
          best_v_q <= 1'b0;
          best_q <= '0;
        end
        StUpd: begin
          init_q[idx_q] <= 1'b1;
          was_q[idx_q] <= alive;
          dcnt_q <= '0;
          if (alive) begin
            if (upd.dl <= 0) util_q <= edf_pkg::UtilMax;
            if (!best_v_q || upd.dl < best_dl_q) begin
              best_v_q <= 1'b1;
              best_q <= idx_q;
              best_dl_q <= upd.dl;
            end
          end
        end
        StDiv: begin
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd48) begin
            util_q <= usum[24] ? edf_pkg::UtilMax : usum[23:0];
          end
        end
        StNext: begin
          idx_q <= idx_q + IdxW'(1);
          cnt_q <= cnt_q + (IdxW+1)'(1);
        end
        StChgW: begin
          if (best_dl_q < 41'($signed({21'd0, slice_q}))) was_q[best_q] <= 1'b0;
        end
        StOut: begin
          rsp_valid_q <= 1'b1;
          rsp_q.selection_valid <= best_v_q;
          rsp_q.chosen_task <= best_v_q ? 3'(best_q) : 3'd0;
          rsp_q.high_freq <= util_q > old_util_q;
          old_util_q <= util_q;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic req_valid;
  logic req_stall;
  edf_pkg::req_t req_data_i;
  logic rsp_valid;
  logic rsp_stall;
  edf_pkg::rsp_t rsp_data_o;
  logic cfg_valid;
  logic cfg_ready;
  logic [19:0] cfg_data_i;

  edf_task_picker_with_freq_hint_core i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data_i(req_data_i),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data_o(rsp_data_o),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data_i(cfg_data_i)
  );

  // Scheduler state mirrored for prediction.
  logic [19:0] slice_us;
  logic [31:0] prof_dl [edf_pkg::TaskCount];
  logic [31:0] prof_ex [edf_pkg::TaskCount];
  logic [edf_pkg::TaskCount-1:0] active;
  logic signed [40:0] rem_dl [edf_pkg::TaskCount];
  logic [39:0] stamp [edf_pkg::TaskCount];
  logic signed [32:0] rem_ex [edf_pkg::TaskCount];
  logic [23:0] prev_util;

  edf_pkg::rsp_t pending_picks[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit hold_rsp;
  bit rand_rsp_stall;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [23:0] util_ratio(logic signed [32:0] ex, logic signed [40:0] dl);
    logic [63:0] q;
    if (dl <= 0) return edf_pkg::UtilMax;
    if (ex <= 0) return 24'd0;
    q = ({31'd0, ex} << 16) / {23'd0, dl};
    return q > 64'hFFFFFF ? edf_pkg::UtilMax : q[23:0];
  endfunction

  function automatic void predict_pick(edf_pkg::req_t r);
    logic [24:0] util;
    int best;
    logic signed [42:0] d;
    logic signed [34:0] e;
    edf_pkg::rsp_t p;
    bit alive;
    if (r.cmd == edf_pkg::CmdLoad) begin
      prof_dl[r.task_index] = r.load_deadline;
      prof_ex[r.task_index] = r.load_exec_time;
      return;
    end
    util = '0;
    best = -1;
    for (int j = 0; j < edf_pkg::TaskCount; j++) begin
      alive = r.alive_mask[j];
      if (!alive && active[j]) begin
        rem_dl[j] = '0;
        rem_ex[j] = '0;
      end else if (alive && !active[j]) begin
        rem_dl[j] = $signed({9'd0, prof_dl[j]});
        stamp[j] = r.now_us;
        rem_ex[j] = $signed({1'b0, prof_ex[j]});
      end else if (alive) begin
        d = rem_dl[j] - ($signed({3'd0, r.now_us}) - $signed({3'd0, stamp[j]}));
        if (d > 43'sd1099511627775) d = 43'sd1099511627775;
        if (d < -43'sd1099511627776) d = -43'sd1099511627776;
        rem_dl[j] = d[40:0];
        stamp[j] = r.now_us;
      end
      if (alive) begin
        util = util + util_ratio(rem_ex[j], rem_dl[j]);
        if (util > 25'hFFFFFF) util = 25'hFFFFFF;
        if (best < 0 || rem_dl[j] < rem_dl[best]) best = j;
      end
      active[j] = alive;
    end
    if (best >= 0) begin
      e = rem_ex[best] - $signed({15'd0, slice_us});
      rem_ex[best] = e < -35'sd4294967296 ? 33'sh100000000 : e[32:0];
      if (rem_dl[best] < $signed({21'd0, slice_us})) begin
        active[best] = 1'b0;
        rem_ex[best] = '0;
      end
    end
    p.selection_valid = best >= 0;
    p.chosen_task = best >= 0 ? best[2:0] : 3'd0;
    p.high_freq = util[23:0] > prev_util;
    prev_util = util[23:0];
    pending_picks.push_back(p);
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    edf_pkg::rsp_t exp_pick;
    if (rst_ni && rsp_valid && !rsp_stall) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp_data_o);
        errors++;
      end else begin
        exp_pick = pending_picks.pop_front();
        if (rsp_data_o.selection_valid !== exp_pick.selection_valid ||
            rsp_data_o.chosen_task !== exp_pick.chosen_task ||
            rsp_data_o.high_freq !== exp_pick.high_freq) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_pick, rsp_data_o);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_rsp) begin
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else if (rand_rsp_stall) begin
      if ($urandom_range(0, 99) < 3) begin
        stall_left = $urandom_range(10, 40);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 3) == 0);
      end
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(edf_pkg::req_t r);
    int g;
    req_data_i <= r;
    req_valid <= 1'b1;
    @(posedge clk_i);
    while (req_stall) @(posedge clk_i);
    predict_pick(r);
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic write_slice(logic [19:0] v);
    cfg_data_i <= v;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    slice_us = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_load(int idx, logic [31:0] dl, logic [31:0] ex);
    edf_pkg::req_t r;
    r = '0;
    r.cmd = edf_pkg::CmdLoad;
    r.task_index = 3'(idx);
    r.load_deadline = dl;
    r.load_exec_time = ex;
    send_request(r);
  endtask

  task automatic send_decide(logic [7:0] m, logic [39:0] t);
    edf_pkg::req_t r;
    r = '0;
    r.cmd = edf_pkg::CmdDecide;
    r.task_index = 3'($urandom);
    r.load_deadline = $urandom;
    r.load_exec_time = $urandom;
    r.alive_mask = m;
    r.now_us = t;
    send_request(r);
  endtask

  task automatic test_directed();
    send_decide(8'h00, 40'd0);
    for (int j = 0; j < edf_pkg::TaskCount; j++)
      send_load(j, j == 0 ? 32'hFFFFFFFF : 32'd20000 * (j + 1),
                j == 1 ? 32'hFFFFFFFF : (j == 2 ? 32'd0 : 32'd3000));
    send_load(7, 32'd0, 32'd500);
    send_decide(8'hFF, 40'd100);
    send_decide(8'hFF, 40'd5000);
    send_decide(8'hFF, 40'd1000);
    send_decide(8'h0F, 40'hFFFFFFFFFF);
    send_decide(8'h0F, 40'd0);
    send_decide(8'h03, 40'd0);
    send_decide(8'h00, 40'd7);
    send_load(3, 32'd50000, 32'd50000);
    send_load(4, 32'd50000, 32'd50000);
    send_decide(8'h18, 40'd10);
    send_decide(8'h18, 40'd10);
    drain();
  endtask

  task automatic test_random(int n, logic [39:0] t0);
    logic [39:0] t;
    int k;
    t = t0;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25) begin
        send_load($urandom_range(0, 7),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 60000));
      end else begin
        k = $urandom_range(0, 19);
        if (k == 0) t = 40'({$urandom, $urandom});
        else if (k == 1) t = t - $urandom_range(0, 50000);
        else t = t + $urandom_range(0, 30000);
        send_decide($urandom_range(0, 9) == 0 ? 8'h00 : 8'($urandom_range(0, 255)), t);
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rsp = 1'b1;
        repeat (1500) @(negedge clk_i);
        hold_rsp = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) send_decide(8'($urandom_range(1, 255)), 40'd500 * i);
        req_valid <= 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    req_valid = 1'b0;
    req_data_i = '0;
    cfg_valid = 1'b0;
    cfg_data_i = '0;
    hold_rsp = 1'b0;
    rand_rsp_stall = 1'b0;
    slice_us = edf_pkg::SliceReset;
    active = '0;
    prev_util = '0;
    for (int j = 0; j < edf_pkg::TaskCount; j++) begin
      prof_dl[j] = '0;
      prof_ex[j] = '0;
      rem_dl[j] = '0;
      stamp[j] = '0;
      rem_ex[j] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    rand_rsp_stall = 1'b1;
    write_slice(20'd1);
    test_random(200, 40'd0);
    drain();
    write_slice(20'hFFFFF);
    test_random(150, 40'd1000000);
    drain();
    write_slice(20'd5000);
    test_backpressure();
    test_random(400, 40'd5000000);
    drain();

    if (errors == 0 && pending_picks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
